>>> rtl/first_fit_block_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit block allocator
// Shared wrappers for concurrent checks clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define FFBA_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication.
`define FFBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

>>> rtl/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Types, codes and constants shared by the allocator cells and top level.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam logic [31:0] MEM_SIZE_RST = 32'd65536;
  localparam logic [32:0] GRAIN_MASK = 33'h0000_000F;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO      = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_NO_MEMORY = 3'd3;
  localparam logic [2:0] ST_NO_NODES  = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INIT,
    OP_SORT,
    OP_FIND_FIT,
    OP_FIND_BASE,
    OP_ALLOC,
    OP_RELEASE,
    OP_MERGE
  } op_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
    logic        used;
  } node_t;

  // Broadcast command from the controller to every cell.
  typedef struct packed {
    op_t         op;
    logic        phase;
    logic        split;
    logic [32:0] need;
    logic [31:0] key;
    logic [31:0] value;
  } cmd_t;

endpackage

>>> rtl/ffba_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_cell
// One table slot: holds a node, swaps and shifts with its neighbors.
// ----------------------------------------------------------------------------
module ffba_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7,
  parameter int IDX_W = 6
) (
  input  logic                clk,
  input  ffba_pkg::cmd_t      cmd,
  input  logic [CNT_W-1:0]    count,
  input  logic [IDX_W-1:0]    target,
  input  ffba_pkg::node_t     left,
  input  ffba_pkg::node_t     right,
  input  logic                hit_in,
  output logic                hit_out,
  output ffba_pkg::node_t     node,
  output ffba_pkg::node_t     sel,
  output logic [IDX_W-1:0]    sel_idx
);

  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NX_CNT = CNT_W'(IDX + 1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam logic             MY_PAR = 1'(IDX % 2);

  ffba_pkg::node_t node_next;
  logic            hit;
  logic            first;
  logic            live;
  logic            has_right;

  assign live      = MY_CNT < count;
  assign has_right = NX_CNT < count;

  always_comb begin
    case (cmd.op)
      ffba_pkg::OP_FIND_FIT:  hit = live && !node.used && ({1'b0, node.size} >= cmd.need);
      ffba_pkg::OP_FIND_BASE: hit = live && (node.base == cmd.key);
      ffba_pkg::OP_MERGE:     hit = has_right && !node.used && !right.used &&
                                    ((node.base + node.size) == right.base);
      default:                hit = 1'b0;
    endcase
  end

  assign first   = hit && !hit_in;
  assign hit_out = hit_in || hit;
  assign sel     = first ? node : '0;
  assign sel_idx = first ? MY_IDX : '0;

  always_comb begin
    node_next = node;
    case (cmd.op)
      ffba_pkg::OP_INIT: begin
        if (IDX == 0) begin
          node_next.base = '0;
          node_next.size = cmd.value;
          node_next.used = 1'b0;
        end
      end
      ffba_pkg::OP_SORT: begin
        // Odd-even transposition: lower cell of a pair takes the right node,
        // upper cell takes the left one, when the pair is out of order.
        if (cmd.phase == MY_PAR && has_right && node.base > right.base) begin
          node_next = right;
        end else if (IDX != 0 && cmd.phase != MY_PAR && live && left.base > node.base) begin
          node_next = left;
        end
      end
      ffba_pkg::OP_ALLOC: begin
        if (target == MY_IDX) begin
          node_next.used = 1'b1;
          if (cmd.split) begin
            node_next.size = cmd.need[31:0];
          end
        end
        if (cmd.split && count == MY_CNT) begin
          node_next.base = cmd.key;
          node_next.size = cmd.value;
          node_next.used = 1'b0;
        end
      end
      ffba_pkg::OP_RELEASE: begin
        if (target == MY_IDX) begin
          node_next.used = 1'b0;
        end
      end
      ffba_pkg::OP_MERGE: begin
        if (first) begin
          node_next.size = node.size + right.size;
        end else if (hit_in) begin
          node_next = right;
        end
      end
      default: node_next = node;
    endcase
  end

  always_ff @(posedge clk) begin
    node <= node_next;
  end

endmodule

>>> rtl/first_fit_block_allocator.sv
`timescale 1ns / 1ps
// Sequence: an allocate goes from S_FIT through S_ALLOC to S_DONE (S_FIT goes
// straight to S_DONE when it is refused); a free runs one S_SORT pass per live
// node, then S_FIND, S_RELEASE, S_MERGE until no pair merges, and S_DONE (S_FIND
// goes straight to S_DONE when the offset is not found).
// Throughput: one request at a time, taken only in S_IDLE; S_DONE waits while
// an earlier result waits for m_tready. Reset (synchronous, rst high) leads to
// S_INIT, which rebuilds node 0 as a 65536-byte free node; requests wait there.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a row of node cells with free-block coalescing.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int MAX_NODES = ffba_pkg::MAX_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: memory_size.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  // Requests. tdata: req_size[31:0], req_offset[63:32]. tuser: req_type.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic [0:0]  s_tuser,
  // Results. tdata: status[2:0], alloc_offset[34:3], allocated_bytes[66:35],
  // zero fill [71:67].
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata
);

  `include "first_fit_block_allocator_assert.svh"

  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int IDX_W = $clog2(MAX_NODES);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NODES);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_FIT, S_ALLOC, S_SORT, S_FIND, S_RELEASE, S_MERGE, S_DONE
  } state_t;

  state_t            state;
  logic [31:0]       mem_size;
  logic [CNT_W-1:0]  count;
  logic [31:0]       used_bytes;
  logic [31:0]       req_size;
  logic [31:0]       req_offset;
  logic [32:0]       need;
  logic [31:0]       hit_base;
  logic [31:0]       hit_size;
  logic [IDX_W-1:0]  target;
  logic [CNT_W-1:0]  pass;
  logic [2:0]        status;
  logic [31:0]       offset;
  logic [71:0]       out_data;
  logic              out_valid;

  ffba_pkg::cmd_t    cmd;
  ffba_pkg::node_t   nodes [MAX_NODES];
  ffba_pkg::node_t   sels  [MAX_NODES];
  logic [IDX_W-1:0]  idxs  [MAX_NODES];
  logic [MAX_NODES:0] hits;
  ffba_pkg::node_t   sel_any;
  logic [IDX_W-1:0]  idx_any;
  logic              any_hit;
  logic              split;

  // The leftover of a fitting node becomes a new node only if there is room.
  assign split = (count < CNT_MAX) && ({1'b0, hit_size} > need);

  always_comb begin
    cmd       = '0;
    cmd.op    = ffba_pkg::OP_HOLD;
    cmd.phase = pass[0];
    cmd.need  = need;
    cmd.key   = req_offset;
    case (state)
      S_INIT: begin
        cmd.op    = ffba_pkg::OP_INIT;
        cmd.value = mem_size;
      end
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.op    = ffba_pkg::OP_INIT;
          cmd.value = cfg_data;
        end
      end
      S_FIT:     cmd.op = ffba_pkg::OP_FIND_FIT;
      S_ALLOC: begin
        cmd.op    = ffba_pkg::OP_ALLOC;
        cmd.split = split;
        cmd.key   = hit_base + need[31:0];
        cmd.value = hit_size - need[31:0];
      end
      S_SORT:    cmd.op = ffba_pkg::OP_SORT;
      S_FIND:    cmd.op = ffba_pkg::OP_FIND_BASE;
      S_RELEASE: cmd.op = ffba_pkg::OP_RELEASE;
      S_MERGE:   cmd.op = ffba_pkg::OP_MERGE;
      default:   cmd.op = ffba_pkg::OP_HOLD;
    endcase
  end

  assign hits[0] = 1'b0;

  // The row of cells; each sees its two neighbors and passes the hit chain on.
  for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
    ffba_pkg::node_t lnode;
    ffba_pkg::node_t rnode;
    if (g == 0) begin : g_lo
      assign lnode = '0;
    end else begin : g_lm
      assign lnode = nodes[g-1];
    end
    if (g == MAX_NODES - 1) begin : g_hi
      assign rnode = '0;
    end else begin : g_rm
      assign rnode = nodes[g+1];
    end
    ffba_cell #(.IDX(g), .CNT_W(CNT_W), .IDX_W(IDX_W)) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .count   (count),
      .target  (target),
      .left    (lnode),
      .right   (rnode),
      .hit_in  (hits[g]),
      .hit_out (hits[g+1]),
      .node    (nodes[g]),
      .sel     (sels[g]),
      .sel_idx (idxs[g])
    );
  end

  // Only the first hitting cell drives its node, so an OR collects it.
  always_comb begin
    sel_any = '0;
    idx_any = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      sel_any = sel_any | sels[i];
      idx_any = idx_any | idxs[i];
    end
  end

  // A configuration write takes priority, so a request is not taken beside it.
  assign any_hit   = hits[MAX_NODES];
  assign s_tready  = (state == S_IDLE) && !rst && !cfg_valid;
  assign cfg_ready = (state == S_IDLE) && !rst;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      mem_size   <= ffba_pkg::MEM_SIZE_RST;
      count      <= CNT_ONE;
      used_bytes <= '0;
      out_valid  <= 1'b0;
      pass       <= '0;
    end else begin
      if (out_valid && m_tready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (cfg_valid) begin
            mem_size   <= cfg_data;
            count      <= CNT_ONE;
            used_bytes <= '0;
          end else if (s_tvalid) begin
            req_size   <= s_tdata[31:0];
            req_offset <= s_tdata[63:32];
            need       <= ({1'b0, s_tdata[31:0]} + ffba_pkg::GRAIN_MASK) &
                          ~ffba_pkg::GRAIN_MASK;
            offset     <= '0;
            pass       <= '0;
            state      <= (s_tuser[0] == ffba_pkg::REQ_FREE) ? S_SORT : S_FIT;
          end
        end
        S_FIT: begin
          hit_base <= sel_any.base;
          hit_size <= sel_any.size;
          target   <= idx_any;
          if (req_size == '0) begin
            status <= ffba_pkg::ST_ZERO;
            state  <= S_DONE;
          end else if (req_size > mem_size) begin
            status <= ffba_pkg::ST_TOO_LARGE;
            state  <= S_DONE;
          end else if (!any_hit) begin
            status <= (count == CNT_MAX) ? ffba_pkg::ST_NO_NODES : ffba_pkg::ST_NO_MEMORY;
            state  <= S_DONE;
          end else begin
            state <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          if (split) begin
            count <= count + CNT_ONE;
          end
          used_bytes <= used_bytes + need[31:0];
          offset     <= hit_base;
          status     <= ffba_pkg::ST_OK;
          state      <= S_DONE;
        end
        S_SORT: begin
          pass <= pass + CNT_ONE;
          if (pass + CNT_ONE >= count) begin
            state <= S_FIND;
          end
        end
        S_FIND: begin
          target   <= idx_any;
          hit_size <= sel_any.size;
          if (!any_hit || !sel_any.used) begin
            status <= ffba_pkg::ST_NOT_FOUND;
            state  <= S_DONE;
          end else begin
            state <= S_RELEASE;
          end
        end
        S_RELEASE: begin
          used_bytes <= used_bytes - hit_size;
          status     <= ffba_pkg::ST_OK;
          state      <= S_MERGE;
        end
        S_MERGE: begin
          if (any_hit) begin
            count <= count - CNT_ONE;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_data  <= {5'b0, used_bytes, offset, status};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FFBA_ASSERT_IMPLIES(a_count_range, 1'b1, (count != '0) && (count <= CNT_MAX))
  `FFBA_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid && s_tready, state != S_IDLE)
  `FFBA_ASSERT_NEXT(a_merge_shrinks, state == S_MERGE && any_hit, count == $past(count) - CNT_ONE)
  `FFBA_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

>>> tb/tb_first_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Self-checking bench for the first-fit allocator. It keeps its own copy of
// the node table, predicts every result, and compares them in order of arrival.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;

  localparam int NODES = ffba_pkg::MAX_NODES_DEF;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // req_size[31:0], req_offset[63:32]
  logic [0:0]  s_tuser;   // req_type
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;   // status[2:0], alloc_offset[34:3], allocated_bytes[66:35]

  // One predicted result of a request.
  typedef struct {
    logic [2:0]  status;
    logic [31:0] offset;
    logic [31:0] bytes;
  } alloc_result_t;

  alloc_result_t pending_results[$];
  logic [31:0]   live_offsets[$];

  // The bench's own copy of the node table and its configuration.
  logic [31:0] tbl_base [NODES];
  logic [31:0] tbl_size [NODES];
  logic        tbl_used [NODES];
  int          tbl_count;
  logic [31:0] tbl_bytes;
  logic [31:0] mem_bytes;

  int errors;
  int requests_sent;
  int results_seen;
  int config_writes;
  int hold_cycles;
  bit steady_ready;

  first_fit_block_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // The clock starts low so that the first rising edge finds reset applied.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Rebuilds the table as one free node covering the whole memory.
  function automatic void table_reset(input logic [31:0] bytes);
    mem_bytes = bytes;
    for (int i = 0; i < NODES; i++) begin
      tbl_base[i] = '0;
      tbl_size[i] = '0;
      tbl_used[i] = 1'b0;
    end
    tbl_size[0] = bytes;
    tbl_count = 1;
    tbl_bytes = '0;
  endfunction

  // Computes the result of one request and updates the table copy.
  function automatic alloc_result_t predict_request(input logic kind,
                                                    input logic [31:0] req_size,
                                                    input logic [31:0] req_off);
    alloc_result_t r;
    logic [32:0] need;
    logic [31:0] b, s;
    logic u;
    int idx, j;
    r.status = ffba_pkg::ST_OK;
    r.offset = '0;
    if (kind == ffba_pkg::REQ_ALLOC) begin
      need = ({1'b0, req_size} + ffba_pkg::GRAIN_MASK) & ~ffba_pkg::GRAIN_MASK;
      idx = -1;
      if (req_size == 0) begin
        r.status = ffba_pkg::ST_ZERO;
      end else if (req_size > mem_bytes) begin
        r.status = ffba_pkg::ST_TOO_LARGE;
      end else begin
        for (int i = 0; i < tbl_count && idx < 0; i++)
          if (!tbl_used[i] && {1'b0, tbl_size[i]} >= need) idx = i;
        if (idx < 0) begin
          r.status = (tbl_count >= NODES) ? ffba_pkg::ST_NO_NODES : ffba_pkg::ST_NO_MEMORY;
        end else begin
          // The leftover becomes a new free node only while the table has room.
          if (tbl_count < NODES && {1'b0, tbl_size[idx]} > need) begin
            tbl_base[tbl_count] = tbl_base[idx] + need[31:0];
            tbl_size[tbl_count] = tbl_size[idx] - need[31:0];
            tbl_used[tbl_count] = 1'b0;
            tbl_count++;
            tbl_size[idx] = need[31:0];
          end
          tbl_used[idx] = 1'b1;
          tbl_bytes += need[31:0];
          r.offset = tbl_base[idx];
        end
      end
    end else begin
      // Stable insertion sort by base, then exact lookup and coalescing.
      for (int i = 1; i < tbl_count; i++) begin
        b = tbl_base[i];
        s = tbl_size[i];
        u = tbl_used[i];
        j = i;
        while (j > 0 && tbl_base[j-1] > b) begin
          tbl_base[j] = tbl_base[j-1];
          tbl_size[j] = tbl_size[j-1];
          tbl_used[j] = tbl_used[j-1];
          j--;
        end
        tbl_base[j] = b;
        tbl_size[j] = s;
        tbl_used[j] = u;
      end
      idx = -1;
      for (int i = 0; i < tbl_count && idx < 0; i++)
        if (tbl_base[i] == req_off) idx = i;
      if (idx < 0 || !tbl_used[idx]) begin
        r.status = ffba_pkg::ST_NOT_FOUND;
      end else begin
        tbl_used[idx] = 1'b0;
        tbl_bytes -= tbl_size[idx];
        j = 0;
        while (j + 1 < tbl_count) begin
          if (!tbl_used[j] && !tbl_used[j+1] && tbl_base[j] + tbl_size[j] == tbl_base[j+1]) begin
            tbl_size[j] += tbl_size[j+1];
            for (int k = j + 1; k + 1 < tbl_count; k++) begin
              tbl_base[k] = tbl_base[k+1];
              tbl_size[k] = tbl_size[k+1];
              tbl_used[k] = tbl_used[k+1];
            end
            tbl_count--;
          end else begin
            j++;
          end
        end
      end
    end
    r.bytes = tbl_bytes;
    return r;
  endfunction

  // Gap length before a request or between ready cycles: mostly short.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Sends one request and predicts its result when it is accepted.
  task automatic send_request(input logic kind, input logic [31:0] req_size,
                              input logic [31:0] req_off, input int gap);
    alloc_result_t r;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {req_off, req_size};
    do @(posedge clk); while (!s_tready);
    r = predict_request(kind, req_size, req_off);
    pending_results.push_back(r);
    requests_sent++;
    // Track live blocks so that the random part frees real allocations.
    if (r.status == ffba_pkg::ST_OK) begin
      if (kind == ffba_pkg::REQ_ALLOC) begin
        live_offsets.push_back(r.offset);
      end else begin
        foreach (live_offsets[i])
          if (live_offsets[i] == req_off) begin
            live_offsets.delete(i);
            break;
          end
      end
    end
  endtask

  task automatic drain_results();
    @(posedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // The register is only written once the block has nothing in flight.
  task automatic write_memory_size(input logic [31:0] bytes);
    drain_results();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= bytes;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    table_reset(bytes);
    live_offsets.delete();
    config_writes++;
  endtask

  // Receiver: checks each accepted result, then decides the next ready.
  always @(posedge clk) begin
    alloc_result_t e;
    int gap;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, m_tdata);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (m_tdata[2:0] !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, m_tdata[2:0]);
          errors++;
        end
        if (m_tdata[34:3] !== e.offset) begin
          $display("%0t: alloc_offset expected %h actual %h", $time, e.offset,
                   m_tdata[34:3]);
          errors++;
        end
        if (m_tdata[66:35] !== e.bytes) begin
          $display("%0t: allocated_bytes expected %h actual %h", $time, e.bytes,
                   m_tdata[66:35]);
          errors++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready <= 1'b0;
    end else if (steady_ready) begin
      m_tready <= 1'b1;
    end else begin
      gap = pick_gap();
      if (gap > 0) hold_cycles = gap - 1;
      m_tready <= (gap == 0);
    end
  end

  task automatic test_directed();
    // Default memory size straight out of reset.
    send_request(ffba_pkg::REQ_ALLOC, 32'd0, 32'hFFFF_FFFF, 0);
    send_request(ffba_pkg::REQ_ALLOC, 32'd1, 32'd0, 0);
    send_request(ffba_pkg::REQ_ALLOC, 32'd16, 32'd0, 1);
    send_request(ffba_pkg::REQ_ALLOC, 32'd17, 32'd0, 0);
    send_request(ffba_pkg::REQ_ALLOC, 32'd65537, 32'd0, 2);
    send_request(ffba_pkg::REQ_ALLOC, 32'hFFFF_FFFF, 32'd0, 0);
    send_request(ffba_pkg::REQ_FREE, 32'hFFFF_FFFF, 32'd16, 0);
    send_request(ffba_pkg::REQ_FREE, 32'd0, 32'd16, 0);
    send_request(ffba_pkg::REQ_FREE, 32'd0, 32'd12345, 0);
    send_request(ffba_pkg::REQ_ALLOC, 32'd65536, 32'd0, 0);
    send_request(ffba_pkg::REQ_FREE, 32'd0, 32'd0, 3);
    send_request(ffba_pkg::REQ_FREE, 32'd0, 32'd48, 0);
    send_request(ffba_pkg::REQ_ALLOC, 32'd65536, 32'd0, 0);
    // Smallest memory: one grain, everything else fails.
    write_memory_size(32'd16);
    send_request(ffba_pkg::REQ_ALLOC, 32'd17, 32'd0, 0);
    send_request(ffba_pkg::REQ_ALLOC, 32'd16, 32'd0, 0);
    send_request(ffba_pkg::REQ_ALLOC, 32'd1, 32'd0, 0);
    send_request(ffba_pkg::REQ_FREE, 32'd0, 32'd0, 0);
    // Largest memory: a whole-memory block and the grain rounding near the top.
    write_memory_size(32'hFFFF_FFF0);
    send_request(ffba_pkg::REQ_ALLOC, 32'hFFFF_FFF1, 32'd0, 0);
    send_request(ffba_pkg::REQ_ALLOC, 32'hFFFF_FFE1, 32'd0, 0);
    send_request(ffba_pkg::REQ_ALLOC, 32'd16, 32'd0, 0);
    send_request(ffba_pkg::REQ_FREE, 32'd0, 32'd0, 0);
    send_request(ffba_pkg::REQ_ALLOC, 32'hFFFF_FFF0, 32'd0, 0);
  endtask

  // Fills the node table: the last fit takes a whole node, then no nodes remain.
  task automatic test_full_table();
    write_memory_size(32'd2048);
    for (int i = 0; i < NODES + 2; i++) send_request(ffba_pkg::REQ_ALLOC, 32'd16, 32'd0, 0);
    for (int i = 0; i < 12; i++) send_request(ffba_pkg::REQ_FREE, 32'd0, 32'(i * 32), 0);
    send_request(ffba_pkg::REQ_ALLOC, 32'd32, 32'd0, 0);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    write_memory_size(32'd65536);
    hold_cycles = 400;
    for (int i = 0; i < 10; i++)
      send_request(ffba_pkg::REQ_ALLOC, 32'($urandom_range(1, 300)), 32'd0, 0);
    drain_results();
    steady_ready = 1'b1;
    for (int i = 0; i < 20; i++)
      send_request(ffba_pkg::REQ_ALLOC, 32'($urandom_range(1, 64)), 32'd0, 0);
    steady_ready = 1'b0;
  endtask

  task automatic test_random(input logic [31:0] bytes, input int count);
    logic [31:0] sz, off;
    int p;
    write_memory_size(bytes);
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(0, 99);
      sz = $urandom;
      off = $urandom;
      if (live_offsets.size() != 0 && p < 45) begin
        p = $urandom_range(0, 9);
        if (p < 8) off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
        else if (p == 8) off = 32'({$urandom_range(0, 8191), 4'h0});
        send_request(ffba_pkg::REQ_FREE, sz, off, pick_gap());
      end else begin
        p = $urandom_range(0, 99);
        if (p < 60) sz = $urandom_range(1, 256);
        else if (p < 75) sz = $urandom_range(1, (bytes > 64) ? bytes / 4 : bytes);
        else if (p < 80) sz = '0;
        else if (p < 88) sz = bytes - 32'($urandom_range(0, 15));
        else if (p < 92) sz = bytes + 32'($urandom_range(1, 15));
        send_request(ffba_pkg::REQ_ALLOC, sz, off, pick_gap());
      end
    end
    // Sender pauses until the block has answered everything.
    drain_results();
  endtask

  initial begin
    errors = 0;
    requests_sent = 0;
    results_seen = 0;
    config_writes = 0;
    hold_cycles = 0;
    steady_ready = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    table_reset(ffba_pkg::MEM_SIZE_RST);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (3) @(posedge clk);

    test_directed();
    test_full_table();
    test_backpressure();
    test_random(32'd65536, 330);
    test_random(32'd2048, 250);
    test_random(32'hFFFF_FFF0, 100);
    test_random(32'd16, 40);
    test_random(32'({$urandom_range(1, 32'h0FFF_FFFF), 4'h0}), 100);

    drain_results();
    repeat (100) @(posedge clk);
    $display("Covered %0d requests and %0d results over %0d memory size settings,",
             requests_sent, results_seen, config_writes);
    $display("including a full node table, long output stalls and edge sizes.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> first_fit_block_allocator.f
+incdir+rtl
rtl/ffba_pkg.sv
rtl/ffba_cell.sv
rtl/first_fit_block_allocator.sv
tb/tb_first_fit_block_allocator.sv
